// ===== rtl/core/bpsp_pkg.sv =====
package bpsp_pkg;

  localparam int unsigned WholeW = 63;
  localparam int unsigned FracW = 24;
  localparam int unsigned FracPartW = 60;
  localparam int unsigned ShiftW = 6;
  localparam logic [2:0] MaxFracDigits = 3'd7;
  localparam logic [2:0] NoPrefix = 3'd7;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_SIGN,
    PH_WHOLE,
    PH_FRAC,
    PH_TRAIL,
    PH_ENDED
  } phase_e;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_INVALID,
    ERR_RANGE
  } err_e;

  typedef enum logic [2:0] {
    S_RUN,
    S_SCALE,
    S_DIV,
    S_SUM,
    S_FIN
  } ctrl_state_e;

  typedef struct packed {
    logic take;
    logic scale;
    logic div_step;
    logic sum;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_busy;
  } sts_t;

  function automatic logic is_white(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  // Return 0..6 for B K M G T P E in either case, NoPrefix otherwise.
  function automatic logic [2:0] prefix_index(input logic [7:0] c);
    logic [7:0] u;
    logic [2:0] p;
    u = (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
    case (u)
      8'h42:   p = 3'd0;
      8'h4B:   p = 3'd1;
      8'h4D:   p = 3'd2;
      8'h47:   p = 3'd3;
      8'h54:   p = 3'd4;
      8'h50:   p = 3'd5;
      8'h45:   p = 3'd6;
      default: p = NoPrefix;
    endcase
    return p;
  endfunction

  function automatic logic [FracW-1:0] pow10(input logic [2:0] n);
    logic [FracW-1:0] r;
    case (n)
      3'd0:    r = 24'd1;
      3'd1:    r = 24'd10;
      3'd2:    r = 24'd100;
      3'd3:    r = 24'd1000;
      3'd4:    r = 24'd10000;
      3'd5:    r = 24'd100000;
      3'd6:    r = 24'd1000000;
      default: r = 24'd10000000;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/bpsp_ctrl.sv =====
module bpsp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          last_i,
  output logic          in_stall_o,
  input  bpsp_pkg::sts_t sts_i,
  output bpsp_pkg::cmd_t cmd_o
);

  bpsp_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bpsp_pkg::S_RUN;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bpsp_pkg::S_RUN: begin
        if (in_valid_i && last_i) state_d = bpsp_pkg::S_SCALE;
      end
      bpsp_pkg::S_SCALE: state_d = bpsp_pkg::S_DIV;
      bpsp_pkg::S_DIV: begin
        if (sts_i.div_done) state_d = bpsp_pkg::S_SUM;
      end
      bpsp_pkg::S_SUM: state_d = bpsp_pkg::S_FIN;
      bpsp_pkg::S_FIN: begin
        if (!sts_i.out_busy) state_d = bpsp_pkg::S_RUN;
      end
      default: state_d = bpsp_pkg::S_RUN;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      bpsp_pkg::S_RUN: begin
        in_stall_o = 1'b0;
        cmd_o.take = in_valid_i;
      end
      bpsp_pkg::S_SCALE: cmd_o.scale = 1'b1;
      bpsp_pkg::S_DIV:   cmd_o.div_step = !sts_i.div_done;
      bpsp_pkg::S_SUM:   cmd_o.sum = 1'b1;
      bpsp_pkg::S_FIN:   cmd_o.finish = !sts_i.out_busy;
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  a_last_starts_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && last_i) |=> (state_q == bpsp_pkg::S_SCALE))
    else $error("last beat did not start the scaling step");

  a_div_exits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bpsp_pkg::S_DIV && sts_i.div_done) |=> (state_q == bpsp_pkg::S_SUM))
    else $error("fraction division did not end when its count ran out");

  a_fin_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bpsp_pkg::S_FIN && sts_i.out_busy) |=> (state_q == bpsp_pkg::S_FIN))
    else $error("result written over a stalled output beat");

endmodule

// ===== rtl/core/bpsp_datapath.sv =====
module bpsp_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          ch_i,
  input  bpsp_pkg::cmd_t      cmd_i,
  output bpsp_pkg::sts_t      sts_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic signed [63:0]  value_o,
  output logic [1:0]          status_o
);

  localparam logic [bpsp_pkg::WholeW-1:0] ValMax = '1;

  // Parse state
  bpsp_pkg::phase_e                phase_q, phase_d;
  bpsp_pkg::err_e                  err_q, err_d;
  logic                            neg_q, neg_d;
  logic [bpsp_pkg::WholeW-1:0]     whole_q, whole_d;
  logic [bpsp_pkg::FracW-1:0]      fv_q, fv_d;
  logic [2:0]                      fc_q, fc_d;
  logic [2:0]                      pow_q, pow_d;

  // Finishing state
  logic [bpsp_pkg::ShiftW-1:0]     cnt_q, cnt_d;
  logic [bpsp_pkg::FracPartW-1:0]  fpart_q, fpart_d;
  logic [63:0]                     acc_q;
  bpsp_pkg::err_e                  fst_q, fst_d;

  // Output register
  logic                            out_valid_q;
  logic signed [63:0]              value_q;
  bpsp_pkg::err_e                  stat_q;

  logic [3:0]                      digit;
  logic [66:0]                     whole_x10;
  logic                            whole_ovf;
  logic [bpsp_pkg::FracW-1:0]      fv_x10;
  logic [2:0]                      pidx;
  logic [bpsp_pkg::ShiftW-1:0]     shift;
  logic [bpsp_pkg::FracW-1:0]      divisor;
  logic [bpsp_pkg::FracW:0]        rem2;
  logic [bpsp_pkg::FracW:0]        rem_sub;
  logic                            rem_ge;
  bpsp_pkg::err_e                  fin_status;
  logic [63:0]                     fin_value;

  assign digit = ch_i[3:0];
  assign whole_x10 = {1'b0, whole_q, 3'b000} + {3'b000, whole_q, 1'b0} + {63'd0, digit};
  assign whole_ovf = whole_x10[66:63] != 4'd0;
  assign fv_x10 = {fv_q[20:0], 3'b000} + {fv_q[22:0], 1'b0} + {20'd0, digit};
  assign pidx = bpsp_pkg::prefix_index(ch_i);
  assign shift = {pow_q, 3'b000} + {2'b00, pow_q, 1'b0};
  assign divisor = bpsp_pkg::pow10(fc_q);
  assign rem2 = {fv_q, 1'b0};
  assign rem_ge = rem2 >= {1'b0, divisor};
  assign rem_sub = rem2 - {1'b0, divisor};

  assign sts_o.div_done = cnt_q == '0;
  assign sts_o.out_busy = out_valid_q && out_stall_i;

  always_comb begin
    fin_status = fst_q;
    if (fst_q == bpsp_pkg::ERR_NONE && acc_q[63]) fin_status = bpsp_pkg::ERR_RANGE;
    if (fin_status != bpsp_pkg::ERR_NONE) begin
      fin_value = '0;
    end else if (neg_q) begin
      fin_value = 64'd0 - acc_q;
    end else begin
      fin_value = acc_q;
    end
  end

  always_comb begin
    phase_d = phase_q;
    err_d   = err_q;
    neg_d   = neg_q;
    whole_d = whole_q;
    fv_d    = fv_q;
    fc_d    = fc_q;
    pow_d   = pow_q;
    cnt_d   = cnt_q;
    fpart_d = fpart_q;
    fst_d   = fst_q;

    if (cmd_i.take && err_q == bpsp_pkg::ERR_NONE) begin
      case (phase_q)
        bpsp_pkg::PH_LEAD: begin
          if (bpsp_pkg::is_white(ch_i)) begin
            phase_d = phase_q;
          end else if (ch_i == 8'h2B || ch_i == 8'h2D) begin
            neg_d   = ch_i == 8'h2D;
            phase_d = bpsp_pkg::PH_SIGN;
          end else if (bpsp_pkg::is_digit(ch_i)) begin
            if (whole_ovf) err_d = bpsp_pkg::ERR_RANGE;
            else whole_d = whole_x10[bpsp_pkg::WholeW-1:0];
            phase_d = bpsp_pkg::PH_WHOLE;
          end else begin
            err_d = bpsp_pkg::ERR_INVALID;
          end
        end
        bpsp_pkg::PH_SIGN: begin
          if (bpsp_pkg::is_digit(ch_i)) begin
            if (whole_ovf) err_d = bpsp_pkg::ERR_RANGE;
            else whole_d = whole_x10[bpsp_pkg::WholeW-1:0];
            phase_d = bpsp_pkg::PH_WHOLE;
          end else begin
            err_d = bpsp_pkg::ERR_INVALID;
          end
        end
        bpsp_pkg::PH_WHOLE, bpsp_pkg::PH_FRAC: begin
          if (bpsp_pkg::is_digit(ch_i)) begin
            if (phase_q == bpsp_pkg::PH_WHOLE) begin
              if (whole_ovf) err_d = bpsp_pkg::ERR_RANGE;
              else whole_d = whole_x10[bpsp_pkg::WholeW-1:0];
            end else if (fc_q < bpsp_pkg::MaxFracDigits) begin
              fv_d = fv_x10;
              fc_d = fc_q + 3'd1;
            end
          end else if (ch_i == 8'h2E && phase_q == bpsp_pkg::PH_WHOLE) begin
            phase_d = bpsp_pkg::PH_FRAC;
          end else if (ch_i == 8'h00) begin
            phase_d = bpsp_pkg::PH_ENDED;
          end else if (bpsp_pkg::is_white(ch_i)) begin
            phase_d = bpsp_pkg::PH_TRAIL;
          end else if (pidx == bpsp_pkg::NoPrefix) begin
            err_d = bpsp_pkg::ERR_INVALID;
          end else begin
            pow_d   = pidx;
            phase_d = bpsp_pkg::PH_TRAIL;
          end
        end
        bpsp_pkg::PH_TRAIL: begin
          if (ch_i == 8'h00) phase_d = bpsp_pkg::PH_ENDED;
          else if (!bpsp_pkg::is_white(ch_i)) err_d = bpsp_pkg::ERR_INVALID;
        end
        default: phase_d = phase_q;
      endcase
    end

    if (cmd_i.scale) begin
      if (err_q != bpsp_pkg::ERR_NONE) begin
        fst_d = err_q;
      end else if (phase_q == bpsp_pkg::PH_LEAD || phase_q == bpsp_pkg::PH_SIGN) begin
        fst_d = bpsp_pkg::ERR_INVALID;
      end else if (whole_q > (ValMax >> shift)) begin
        fst_d = bpsp_pkg::ERR_RANGE;
      end else begin
        fst_d = bpsp_pkg::ERR_NONE;
      end
      whole_d = whole_q << shift;
      cnt_d   = shift;
      fpart_d = '0;
    end

    // One quotient bit of fraction * 2^shift / 10^digits per step
    if (cmd_i.div_step) begin
      fv_d    = rem_ge ? rem_sub[bpsp_pkg::FracW-1:0] : rem2[bpsp_pkg::FracW-1:0];
      fpart_d = {fpart_q[bpsp_pkg::FracPartW-2:0], rem_ge};
      cnt_d   = cnt_q - 1'b1;
    end

    // Drop the parse state once the result is in the output register
    if (cmd_i.finish) begin
      phase_d = bpsp_pkg::PH_LEAD;
      err_d   = bpsp_pkg::ERR_NONE;
      neg_d   = 1'b0;
      whole_d = '0;
      fv_d    = '0;
      fc_d    = '0;
      pow_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= bpsp_pkg::PH_LEAD;
      err_q       <= bpsp_pkg::ERR_NONE;
      neg_q       <= 1'b0;
      whole_q     <= '0;
      fv_q        <= '0;
      fc_q        <= '0;
      pow_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      err_q   <= err_d;
      neg_q   <= neg_d;
      whole_q <= whole_d;
      fv_q    <= fv_d;
      fc_q    <= fc_d;
      pow_q   <= pow_d;
      cnt_q   <= cnt_d;
      if (cmd_i.finish) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    fpart_q <= fpart_d;
    fst_q   <= fst_d;
    if (cmd_i.sum) acc_q <= {1'b0, whole_q} + {4'd0, fpart_q};
    if (cmd_i.finish) begin
      value_q <= fin_value;
      stat_q  <= fin_status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o = value_q;
  assign status_o = stat_q;

  a_frac_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fc_q <= bpsp_pkg::MaxFracDigits)
    else $error("fraction digit count past its limit");

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (fv_q < divisor))
    else $error("fraction remainder not below its divisor");

  a_err_latched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != bpsp_pkg::ERR_NONE && !cmd_i.finish) |=> (err_q == $past(err_q)))
    else $error("latched error changed before the result");

endmodule

// ===== rtl/core/binary_prefix_size_parser.sv =====
// Binary-prefix size text parser.
// Input channel: one character per beat on ch_i with last_i marking the final
// character of a text (in_valid_i / in_stall_o). White space, an optional sign,
// digits, an optional fraction and one optional B K M G T P E prefix
// (each step x1024) are read; a zero character ends the text early.
// Output channel: one beat per text (out_valid_o / out_stall_i) with the
// signed byte count on value_o and status_o (0 ok, 1 invalid, 2 out of range);
// value_o is zero when status_o is not ok.
// Throughput: one character per cycle while a text streams in. After the last
// beat the block stalls its input through a scaling step, one bit of the
// fraction quotient per cycle from the restoring divider, then a sum step and
// a sign step. A waiting result does not block the next text: characters are
// taken while the output is stalled; only the final sign step holds until the
// output register is free. Reset empties the output and starts a fresh text.
module binary_prefix_size_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         ch_i,
  input  logic               last_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [63:0] value_o,
  output logic [1:0]         status_o
);

  bpsp_pkg::cmd_t cmd;
  bpsp_pkg::sts_t sts;

  bpsp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .last_i     (last_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bpsp_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ch_i        (ch_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .value_o     (value_o),
    .status_o    (status_o)
  );

endmodule
